// ===== rtl/olve_pkg.sv =====
// Shared constants, codes and types of the ordered value list engine.
package olve_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_DISPLAY = 3'd1,
        OP_SEARCH  = 3'd2,
        OP_MODIFY  = 3'd3,
        OP_DELETE  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4
    } t_status;

    // Broadcast control from the sequencer to every cell of the chain.
    typedef struct packed {
        logic              shift;
        logic              rotate;
        logic [IDX_W-1:0]  tail_idx;
        logic [DATA_W-1:0] tail_data;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [DATA_W-1:0] wr_data;
    } t_cell_ctl;

endpackage

// ===== rtl/ordered_value_list_engine.sv =====
// Top level of the ordered value list engine: the cell chain and its sequencer.
//
// Input channel (s_axis): one item carries an operation in tuser (insert, display,
// search, modify, delete) and the value and replacement value in tdata. Output
// channel (m_axis): result items carry a status in tuser and an entry value in
// tdata; tlast marks the final result of an input item.
// Entries live in a chain of DEPTH cells. Insert writes the cell at the fill count.
// Display, search, modify and delete rotate the live entries once around the chain,
// one entry per cycle past the head cell, display only while the output register
// is free. Display sends each entry as it passes the head. A delete drops the
// matching entry out of the rotation, which closes the gap in order. Unknown
// operation codes are consumed with no result.
// The next item is accepted once the sequencer is idle, even while the last
// result still sits in the output register. A stalled receiver holds the output
// register and, during display, freezes the rotation until it takes the item.
// Reset empties the list at once; the cell contents are not cleared.
module ordered_value_list_engine import olve_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value [31:0], new_value [63:32]
    input  logic [2:0]  s_axis_tuser,   // operation [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // item_value [31:0]
    output logic [2:0]  m_axis_tuser,   // status [2:0]
    output logic        m_axis_tlast    // last
);

    t_cell_ctl         w_ctl;
    logic [DATA_W-1:0] w_cell [DEPTH];

    olve_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_head        (w_cell[0]),
        .o_ctl         (w_ctl)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_next;
        if (g == DEPTH - 1) begin : g_end
            assign w_next = w_cell[g];
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end
        olve_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (IDX_W'(g)),
            .i_next  (w_next),
            .o_value (w_cell[g])
        );
    end

endmodule

// ===== rtl/olve_cell.sv =====
// One storage cell of the list chain: holds one entry and passes it toward the head.
module olve_cell import olve_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [DATA_W-1:0] i_next,
    output logic [DATA_W-1:0] o_value
);

    logic [DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_index == i_ctl.wr_idx)) begin
            r_value <= i_ctl.wr_data;
        end else if (i_ctl.shift) begin
            // The tail cell of the live ring takes the value leaving the head.
            if (i_ctl.rotate && (i_index == i_ctl.tail_idx)) begin
                r_value <= i_ctl.tail_data;
            end else begin
                r_value <= i_next;
            end
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/olve_ctrl.sv =====
// Sequencer of the list engine: decodes items, walks the cell ring and drives results.
module olve_ctrl import olve_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,
    input  logic [2:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    input  logic [DATA_W-1:0] i_head,
    output t_cell_ctl         o_ctl
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_EMIT} t_state;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [DATA_W-1:0] r_key, n_key;
    logic [DATA_W-1:0] r_nval, n_nval;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_step, n_step;
    logic              r_found, n_found;
    t_status           r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic              r_out_last, n_out_last;

    logic w_out_free;
    logic w_last_step;
    logic w_match;

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_last_step = (r_step == (r_count - 1'b1));
    assign w_match     = (i_head == r_key) && !r_found;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_nval       = r_nval;
        n_count      = r_count;
        n_len        = r_len;
        n_step       = r_step;
        n_found      = r_found;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;

        o_ctl           = '0;
        o_ctl.tail_idx  = IDX_W'(r_len - 1'b1);
        o_ctl.tail_data = i_head;
        o_ctl.wr_idx    = r_count[IDX_W-1:0];
        o_ctl.wr_data   = s_axis_tdata[DATA_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (t_op'(s_axis_tuser))
                        OP_INSERT: begin
                            n_state = S_EMIT;
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_pend = ST_FULL;
                            end else begin
                                o_ctl.wr_en = 1'b1;
                                n_count     = r_count + 1'b1;
                                n_pend      = ST_DONE;
                            end
                        end
                        OP_DISPLAY, OP_SEARCH, OP_MODIFY, OP_DELETE: begin
                            if (r_count == '0) begin
                                n_pend  = ST_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_op    = t_op'(s_axis_tuser);
                                n_key   = s_axis_tdata[DATA_W-1:0];
                                n_nval  = s_axis_tdata[2*DATA_W-1:DATA_W];
                                n_len   = r_count;
                                n_step  = '0;
                                n_found = 1'b0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_op == OP_DISPLAY) begin
                    // Each entry passes the head once; the ring stalls with the receiver.
                    if (w_out_free) begin
                        o_ctl.shift  = 1'b1;
                        o_ctl.rotate = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_status = ST_ENTRY;
                        n_out_value  = i_head;
                        n_out_last   = w_last_step;
                        n_step       = r_step + 1'b1;
                        if (w_last_step) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    o_ctl.shift  = 1'b1;
                    // A deleted entry is dropped from the ring instead of going to the tail.
                    o_ctl.rotate = !(w_match && (r_op == OP_DELETE));
                    if (w_match && (r_op == OP_MODIFY)) begin
                        o_ctl.tail_data = r_nval;
                    end
                    if (w_match) begin
                        n_found = 1'b1;
                        if (r_op == OP_DELETE) begin
                            n_len = r_len - 1'b1;
                        end
                    end
                    n_step = r_step + 1'b1;
                    if (w_last_step) begin
                        n_state = S_EMIT;
                        n_pend  = (r_found || w_match) ? ST_DONE : ST_NOT_FOUND;
                        if ((r_op == OP_DELETE) && (r_found || w_match)) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_len       <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_len       <= n_len;
            r_step      <= n_step;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_nval       <= n_nval;
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds the list depth");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_step < r_count))
        else $error("ring walk ran past the entry count");

    a_walk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |->
            (((r_op == OP_DELETE) && r_found) ? ((r_len + 1'b1) == r_count)
                                              : (r_len == r_count)))
        else $error("live ring length out of step with the walk");

    a_walk_ends_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && (r_op != OP_DISPLAY) && w_last_step)
            |=> (r_state == S_EMIT))
        else $error("search walk did not finish with a status");

endmodule

// ===== sim/tb_ordered_value_list_engine.sv =====
// Self-checking testbench for the ordered value list engine, with a built-in list predictor.
`timescale 1ns / 100ps

module tb_ordered_value_list_engine;
    import olve_pkg::*;

    localparam int IDLE_PCT      = 19;
    localparam int RANDOM_ITEMS  = 420;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_FIRST = 150;
    localparam int HOLD_AT_LATER = 600;
    localparam int TAIL_CYCLES   = 40;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int MAX_REPORTS   = 60;
    localparam int SCRIPT_LEN    = 21;

    // Operation codes the block consumes without any result.
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_CHURN = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
        logic        last;
    } t_list_result;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] repl;
        logic        typed;
        t_status     status;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;  // value [31:0], new_value [63:32]
    logic [2:0]  s_axis_tuser  = '0;  // operation [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // item_value [31:0]
    logic [2:0]  m_axis_tuser;        // status [2:0]
    logic        m_axis_tlast;

    // Predicted contents of the list and the results still owed by the block.
    logic [31:0]  list_vals [DEPTH];
    int           list_len = 0;
    t_list_result pending_results [$];

    logic idle_on      = 1'b1;
    int   error_count  = 0;
    int   results_seen = 0;
    int   stall_left   = 0;
    int   cycle_count  = 0;

    t_script_row script [SCRIPT_LEN] = '{
        '{OP_DISPLAY,        32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_SEARCH,         32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_EMPTY},
        '{OP_MODIFY,         32'h0000_0000, 32'h1234_5678, 1'b1, ST_EMPTY},
        '{OP_DELETE,         32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_RESERVED_LAST,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_DONE},
        '{OP_INSERT,         32'h8000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DELETE,         32'h8000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DISPLAY,        32'h0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_INSERT,         32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_INSERT,         32'h8000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_INSERT,         32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_INSERT,         32'h0000_0000, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_SEARCH,         32'h0000_3039, 32'h0000_0000, 1'b1, ST_NOT_FOUND},
        '{OP_SEARCH,         32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_MODIFY,         32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_DONE},
        '{OP_MODIFY,         32'h0000_002A, 32'h0000_0001, 1'b1, ST_NOT_FOUND},
        '{OP_DELETE,         32'h0000_002A, 32'h0000_0000, 1'b1, ST_NOT_FOUND},
        '{OP_DISPLAY,        32'h0000_0000, 32'h0000_0000, 1'b0, ST_DONE},
        '{OP_DELETE,         32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_DONE},
        '{OP_DISPLAY,        32'h0000_0000, 32'h0000_0000, 1'b0, ST_DONE},
        '{OP_RESERVED_FIRST, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_DONE}
    };

    ordered_value_list_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void owe_result(input logic record, input t_status status,
                                       input logic [31:0] value, input logic last);
        if (record)
            pending_results.push_back('{status, value, last});
    endfunction

    // Applies one accepted operation to the predicted list and, when record is set, queues its results.
    function automatic void apply_list_op(input logic [2:0] op, input logic [31:0] key,
                                          input logic [31:0] repl, input logic record);
        int hit;
        hit = -1;
        for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_vals[i] == key)
                hit = i;
        case (op)
            OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    owe_result(record, ST_FULL, '0, 1'b1);
                end else begin
                    list_vals[list_len] = key;
                    list_len++;
                    owe_result(record, ST_DONE, '0, 1'b1);
                end
            end
            OP_DISPLAY: begin
                if (list_len == 0)
                    owe_result(record, ST_EMPTY, '0, 1'b1);
                for (int i = 0; i < list_len; i++)
                    owe_result(record, ST_ENTRY, list_vals[i], i == list_len - 1);
            end
            OP_SEARCH, OP_MODIFY, OP_DELETE: begin
                if (list_len == 0) begin
                    owe_result(record, ST_EMPTY, '0, 1'b1);
                end else if (hit < 0) begin
                    owe_result(record, ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    if (op == OP_MODIFY) begin
                        list_vals[hit] = repl;
                    end else if (op == OP_DELETE) begin
                        for (int i = hit; i + 1 < list_len; i++)
                            list_vals[i] = list_vals[i + 1];
                        list_len--;
                    end
                    owe_result(record, ST_DONE, '0, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // Extremes and a small pool of repeated values, so that duplicates show up often.
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        if (roll < 35)
            return $urandom_range(0, 3);
        return $urandom;
    endfunction

    // Keys mostly hit a live entry so that modify and delete do real work.
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (list_len > 0 && roll < 60)
            return list_vals[$urandom_range(0, list_len - 1)];
        return pick_value();
    endfunction

    task automatic offer_item(input logic [2:0] op, input logic [31:0] key,
                              input logic [31:0] repl);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {repl, key};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endtask

    // Result checker; it also drives the receiver's ready, including its long hold-off.
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected item expected none actual %0d/%h/%b",
                                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                    if (m_axis_tdata !== want.value)
                        report_mismatch("item_value", want.value, m_axis_tdata);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", 32'(want.last), 32'(m_axis_tlast));
                end
                results_seen++;
                if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_LATER)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ordered_value_list_engine: mismatch");
        $finish;
    end

    initial begin
        int          sent;
        int          mode;
        int          insert_pct;
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] repl;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            offer_item(script[r].op, script[r].key, script[r].repl);
            apply_list_op(script[r].op, script[r].key, script[r].repl, !script[r].typed);
            if (script[r].typed)
                owe_result(1'b1, script[r].status, '0, 1'b1);
            maybe_idle();
        end
        wait_drained();

        // Random part: fill, churn and drain phases, chosen at random, keep the list moving
        // between empty and full.
        sent = 0;
        mode = MODE_FILL;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 40 == 0 && sent != 0)
                mode = $urandom_range(MODE_FILL, MODE_DRAIN);
            if (sent == 200)
                idle_on <= 1'b0;
            else if (sent == 300)
                idle_on <= 1'b1;
            case (mode)
                MODE_FILL:  insert_pct = 75;
                MODE_CHURN: insert_pct = 30;
                default:    insert_pct = 10;
            endcase

            repl = ($urandom_range(0, 1) != 0) ? pick_value() : $urandom;
            if ($urandom_range(0, 99) < 3) begin
                op  = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
                key = $urandom;
            end else begin
                if ($urandom_range(0, 99) < insert_pct) begin
                    op  = OP_INSERT;
                    key = pick_value();
                end else begin
                    case ($urandom_range(0, 4))
                        0:       op = OP_DISPLAY;
                        1:       op = OP_SEARCH;
                        2:       op = OP_MODIFY;
                        default: op = OP_DELETE;
                    endcase
                    key = pick_key();
                end
                sent++;
            end

            offer_item(op, key, repl);
            apply_list_op(op, key, repl, 1'b1);
            if (sent == 150)
                wait_drained();
            else
                maybe_idle();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("ordered_value_list_engine: match");
        else
            $display("ordered_value_list_engine: mismatch");
        $finish;
    end

endmodule
